// ----- sv/chebpe_pkg.sv -----
// Shared types and fixed widths for the Chebyshev polynomial evaluator.
// Used by chebpe_datapath and chebyshev_polynomial_eval; depends on nothing.
package chebpe_pkg;

  // Widths fixed by the interface and by the internal clamp range
  localparam int X_W    = 18;           // abscissa width
  localparam int DEG_W  = 5;            // degree field width
  localparam int OUT_W  = 32;           // result width
  localparam int VAL_W  = 42;           // recurrence value, holds +-2^40
  localparam int PROD_W = X_W + VAL_W;  // x * value
  localparam int SUM_W  = PROD_W + 2;   // 2 * product plus rounding headroom

  localparam logic signed [VAL_W-1:0] INNER_LIM = VAL_W'(64'sd1 <<< 40);
  localparam logic signed [OUT_W-1:0] OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  // Sequencer commands to the datapath
  typedef struct packed {
    logic load;      // start a new item
    logic mul_en;    // capture x * current value
    logic acc_en;    // round, subtract, clamp and shift the recurrence
    logic use_prev;  // degree zero: result is the initial P0
  } chebpe_ctrl_t;

endpackage

// ----- sv/chebpe_datapath.sv -----
// Recurrence datapath: one shared multiplier and one add/clamp stage.
// Depends on chebpe_pkg for widths and the control struct.
module chebpe_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  chebpe_pkg::chebpe_ctrl_t              ctrl,
  input  logic                                  kind,
  input  logic signed [chebpe_pkg::X_W-1:0]     abscissa,
  output logic signed [chebpe_pkg::OUT_W-1:0]   value,
  output logic                                  saturated
);

  localparam logic signed [chebpe_pkg::VAL_W-1:0] ONE_FIX =
    chebpe_pkg::VAL_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [chebpe_pkg::SUM_W-1:0] HALF_FIX =
    chebpe_pkg::SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [chebpe_pkg::VAL_W-1:0] OUT_MAX_EXT =
    chebpe_pkg::VAL_W'(chebpe_pkg::OUT_MAX);
  localparam logic signed [chebpe_pkg::VAL_W-1:0] OUT_MIN_EXT =
    chebpe_pkg::VAL_W'(chebpe_pkg::OUT_MIN);

  logic signed [chebpe_pkg::X_W-1:0]    x_r;
  logic signed [chebpe_pkg::VAL_W-1:0]  prev_r, cur_r;
  logic signed [chebpe_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                                 over_r;

  logic signed [chebpe_pkg::VAL_W-1:0]  cur_init;
  logic signed [chebpe_pkg::SUM_W-1:0]  rnd, shifted, diff;
  logic signed [chebpe_pkg::VAL_W-1:0]  next_val;
  logic                                 next_over;
  logic signed [chebpe_pkg::VAL_W-1:0]  res;

  // P1 is x for the first kind, 2x for the second
  assign cur_init = kind ?
    {{(chebpe_pkg::VAL_W-chebpe_pkg::X_W-1){abscissa[chebpe_pkg::X_W-1]}}, abscissa, 1'b0} :
    {{(chebpe_pkg::VAL_W-chebpe_pkg::X_W){abscissa[chebpe_pkg::X_W-1]}}, abscissa};

  // Shared multiplier: x times the current value
  assign prod_nxt = x_r * cur_r;

  // Double, round half up, subtract P(k-2), clamp to the inner range
  always_comb begin
    rnd       = {prod_r[chebpe_pkg::PROD_W-1], prod_r, 1'b0} + HALF_FIX;
    shifted   = rnd >>> FRAC_BITS;
    diff      = shifted - chebpe_pkg::SUM_W'(prev_r);
    next_over = 1'b0;
    next_val  = diff[chebpe_pkg::VAL_W-1:0];
    if (diff > chebpe_pkg::SUM_W'(chebpe_pkg::INNER_LIM)) begin
      next_over = 1'b1;
      next_val  = chebpe_pkg::INNER_LIM;
    end else if (diff < -chebpe_pkg::SUM_W'(chebpe_pkg::INNER_LIM)) begin
      next_over = 1'b1;
      next_val  = -chebpe_pkg::INNER_LIM;
    end
  end

  // Hold operands and recurrence state
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r    <= abscissa;
      prev_r <= ONE_FIX;
      cur_r  <= cur_init;
      over_r <= 1'b0;
    end else if (ctrl.acc_en) begin
      prev_r <= cur_r;
      cur_r  <= next_val;
      over_r <= over_r | next_over;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Saturate the final value to 32 bits
  always_comb begin
    res       = ctrl.use_prev ? prev_r : cur_r;
    saturated = 1'b1;
    if (over_r) begin
      value = res[chebpe_pkg::VAL_W-1] ? chebpe_pkg::OUT_MIN : chebpe_pkg::OUT_MAX;
    end else if (res > OUT_MAX_EXT) begin
      value = chebpe_pkg::OUT_MAX;
    end else if (res < OUT_MIN_EXT) begin
      value = chebpe_pkg::OUT_MIN;
    end else begin
      value     = res[chebpe_pkg::OUT_W-1:0];
      saturated = 1'b0;
    end
  end

endmodule

// ----- sv/chebyshev_polynomial_eval.sv -----
// Chebyshev polynomial evaluator top level: sequencer and output register.
// Depends on chebpe_pkg and chebpe_datapath.
//
// Computes T_n(x) (kind 0) or U_n(x) (kind 1) by the three-term recurrence
// P(k) = 2x*P(k-1) - P(k-2), rounded half up to FRAC_BITS fraction bits at
// each step. Degrees above MAX_DEGREE are clamped to MAX_DEGREE. Internal
// values are held within +-2^40; if that clamp ever acts, or the final value
// leaves the signed 32-bit range, the result is clamped and saturated is set.
// For n >= 2 each recurrence step passes through S_MUL, on the shared 18x42
// multiplier, and then S_ACC, on the round/subtract/clamp stage; after the
// last step S_FIN loads the output register, and waits while a held result
// is not yet taken. For n of 0 or 1 the transfer leads straight to S_FIN.
// The next item can transfer once S_FIN has loaded the result, so one item
// is finished before the next is taken. in_ready is high only while no item
// is in work; a finished result waits in the output register, and the next
// item can be taken while it waits.
module chebyshev_polynomial_eval #(
  parameter int MAX_DEGREE = 31,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic [chebpe_pkg::DEG_W-1:0]          in_degree,
  input  logic signed [chebpe_pkg::X_W-1:0]     in_abscissa,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [chebpe_pkg::OUT_W-1:0]   out_value,
  output logic                                  out_saturated
);

  localparam int CNT_W = $clog2(MAX_DEGREE + 1);
  localparam logic [CNT_W-1:0] MAX_DEG_C = CNT_W'(MAX_DEGREE);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_FIN
  } state_t;

  state_t                            state_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic                              zero_r;
  logic                              out_valid_r;
  logic signed [chebpe_pkg::OUT_W-1:0] out_value_r;
  logic                              out_sat_r;

  chebpe_pkg::chebpe_ctrl_t          ctrl;
  logic                              in_xfer;
  logic [CNT_W-1:0]                  deg_ext, deg_clamped;
  logic signed [chebpe_pkg::OUT_W-1:0] dp_value;
  logic                              dp_sat;

  assign in_ready      = (state_r == S_IDLE);
  assign in_xfer       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

  // Clamp the requested degree
  assign deg_ext     = CNT_W'(in_degree);
  assign deg_clamped = ((CNT_W > chebpe_pkg::DEG_W) || (deg_ext <= MAX_DEG_C)) &&
                       ({1'b0, in_degree} <= (chebpe_pkg::DEG_W+1)'(MAX_DEGREE)) ?
                       deg_ext : MAX_DEG_C;

  // Datapath commands
  always_comb begin
    ctrl.load     = in_xfer;
    ctrl.mul_en   = (state_r == S_MUL);
    ctrl.acc_en   = (state_r == S_ACC);
    ctrl.use_prev = zero_r;
  end

  chebpe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .kind      (in_kind),
    .abscissa  (in_abscissa),
    .value     (dp_value),
    .saturated (dp_sat)
  );

  // Sequence the recurrence and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      zero_r      <= 1'b0;
    end else begin
      // Drop the held result on transfer unless a new one replaces it
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            cnt_r   <= deg_clamped;
            zero_r  <= (deg_clamped == '0);
            state_r <= (deg_clamped < LAST_STEP) ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (cnt_r == LAST_STEP) begin
            state_r <= S_FIN;
          end else begin
            cnt_r   <= cnt_r - CNT_W'(1);
            state_r <= S_MUL;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= dp_value;
            out_sat_r   <= dp_sat;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for chebyshev_polynomial_eval: directed table, then random items.
// Holds its own recurrence predictor and randomizes idle gaps on both handshakes.
// Depends on chebpe_pkg and the chebyshev_polynomial_eval RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int X_W   = chebpe_pkg::X_W;
  localparam int DEG_W = chebpe_pkg::DEG_W;
  localparam int OUT_W = chebpe_pkg::OUT_W;
  localparam logic signed [OUT_W-1:0] OUT_MAX = chebpe_pkg::OUT_MAX;
  localparam logic signed [OUT_W-1:0] OUT_MIN = chebpe_pkg::OUT_MIN;

  localparam int MAX_DEG      = 31;
  localparam int FRACW        = 16;
  localparam int N_RANDOM     = 1750;
  localparam int STALL_LIMIT  = 5000;  // cycles without any transfer
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int HOLD_AT      = 200;   // results seen before the hold-off
  localparam int DRAIN_CYCLES = 80;    // wait after the last expected result
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } cheb_result_t;

  typedef struct packed {
    logic                    kind;
    logic [DEG_W-1:0]        degree;
    logic signed [X_W-1:0]   abscissa;
    logic                    has_exp;   // expected value typed in below
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } stim_row_t;

  localparam int N_DIRECTED = 24;

  // kind, degree, abscissa, typed, value, saturated
  localparam stim_row_t DIR_ROWS [N_DIRECTED] = '{
    '{1'b0, 5'd0,  18'sd0,       1'b1, 32'sd65536,    1'b0},  // degree zero is one
    '{1'b1, 5'd0,  -18'sd65536,  1'b1, 32'sd65536,    1'b0},
    '{1'b0, 5'd1,  18'sd65536,   1'b1, 32'sd65536,    1'b0},
    '{1'b1, 5'd1,  -18'sd131072, 1'b1, -32'sd262144,  1'b0},  // most negative x
    '{1'b0, 5'd31, 18'sd65536,   1'b1, 32'sd65536,    1'b0},  // T_n(1) = 1
    '{1'b1, 5'd31, 18'sd65536,   1'b1, 32'sd2097152,  1'b0},  // U_n(1) = n+1
    '{1'b0, 5'd31, -18'sd65536,  1'b1, -32'sd65536,   1'b0},
    '{1'b1, 5'd31, -18'sd65536,  1'b1, -32'sd2097152, 1'b0},
    '{1'b0, 5'd2,  18'sd0,       1'b1, -32'sd65536,   1'b0},
    '{1'b1, 5'd2,  18'sd0,       1'b1, -32'sd65536,   1'b0},
    '{1'b0, 5'd3,  18'sd0,       1'b1, 32'sd0,        1'b0},
    '{1'b0, 5'd31, 18'sd131071,  1'b0, 32'sd0,        1'b0},  // inner clamp
    '{1'b1, 5'd31, -18'sd131072, 1'b0, 32'sd0,        1'b0},
    '{1'b0, 5'd16, 18'sd131071,  1'b0, 32'sd0,        1'b0},
    '{1'b1, 5'd10, 18'sd131071,  1'b0, 32'sd0,        1'b0},  // 32-bit saturation
    '{1'b0, 5'd10, -18'sd131072, 1'b0, 32'sd0,        1'b0},
    '{1'b0, 5'd5,  18'sd32768,   1'b0, 32'sd0,        1'b0},
    '{1'b1, 5'd7,  -18'sd12345,  1'b0, 32'sd0,        1'b0},
    '{1'b0, 5'd20, 18'sd1,       1'b0, 32'sd0,        1'b0},  // rounding of tiny x
    '{1'b1, 5'd20, -18'sd1,      1'b0, 32'sd0,        1'b0},
    '{1'b0, 5'd1,  -18'sd1,      1'b1, -32'sd1,       1'b0},
    '{1'b1, 5'd1,  18'sd131071,  1'b1, 32'sd262142,   1'b0},  // most positive x
    '{1'b0, 5'd25, 18'sd65535,   1'b0, 32'sd0,        1'b0},
    '{1'b1, 5'd0,  18'sd131071,  1'b1, 32'sd65536,    1'b0}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_kind;
  logic [DEG_W-1:0]        in_degree;
  logic signed [X_W-1:0]   in_abscissa;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] out_value;
  logic                    out_saturated;

  cheb_result_t pending_q[$];
  int           errors;
  int           results_seen;
  int           snd_burst;
  int           rcv_burst;

  chebyshev_polynomial_eval #(
    .MAX_DEGREE(MAX_DEG),
    .FRAC_BITS (FRACW)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_degree    (in_degree),
    .in_abscissa  (in_abscissa),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Three-term recurrence with per-step rounding, inner clamp and output clamp
  function automatic cheb_result_t cheb_eval(input logic kind, input logic [DEG_W-1:0] degree,
                                             input logic signed [X_W-1:0] abscissa);
    longint       xv;
    longint       p_prev;
    longint       p_cur;
    longint       p_next;
    longint       inner_lim;
    longint       fin;
    bit           clipped;
    int           n;
    cheb_result_t r;
    xv        = abscissa;
    inner_lim = 64'sd1 <<< 40;
    p_prev    = 64'sd1 <<< FRACW;
    p_cur     = kind ? 2 * xv : xv;
    clipped   = 1'b0;
    n         = degree;
    if (n > MAX_DEG) n = MAX_DEG;
    for (int k = 2; k <= n; k++) begin
      // round half up: add half an LSB, then floor
      p_next = ((2 * xv * p_cur + (64'sd1 <<< (FRACW - 1))) >>> FRACW) - p_prev;
      if (p_next > inner_lim) begin
        p_next  = inner_lim;
        clipped = 1'b1;
      end else if (p_next < -inner_lim) begin
        p_next  = -inner_lim;
        clipped = 1'b1;
      end
      p_prev = p_cur;
      p_cur  = p_next;
    end
    fin   = (n == 0) ? p_prev : p_cur;
    r.sat = 1'b1;
    if (clipped) fin = (fin < 0) ? longint'(OUT_MIN) : longint'(OUT_MAX);
    else if (fin > longint'(OUT_MAX)) fin = longint'(OUT_MAX);
    else if (fin < longint'(OUT_MIN)) fin = longint'(OUT_MIN);
    else r.sat = 1'b0;
    r.value = fin[OUT_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and bursts with no gap at all
  function automatic int idle_len(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [X_W-1:0] pick_abscissa();
    int          r;
    int          v;
    logic [31:0] w;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      v = int'($urandom_range(0, 131072)) - 65536;
      return v[X_W-1:0];
    end
    if (r < 85) begin
      case ($urandom_range(0, 6))
        0: v = -65536;
        1: v = 65536;
        2: v = 0;
        3: v = 1;
        4: v = -1;
        5: v = 131071;
        default: v = -131072;
      endcase
      return v[X_W-1:0];
    end
    // anywhere in the 18-bit range, far outside [-1,1] included
    w = $urandom();
    return w[X_W-1:0];
  endfunction

  function automatic logic [DEG_W-1:0] pick_degree();
    if ($urandom_range(0, 99) < 80) return DEG_W'($urandom_range(0, 31));
    case ($urandom_range(0, 3))
      0: return DEG_W'(0);
      1: return DEG_W'(1);
      2: return DEG_W'(2);
      default: return DEG_W'(31);
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  // Offer one item, hold it until the transfer, then queue its expected result
  task automatic offer(input stim_row_t row);
    int gap;
    gap = idle_len(snd_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= row.kind;
    in_degree   <= row.degree;
    in_abscissa <= row.abscissa;
    do @(posedge clk); while (!in_ready);
    if (row.has_exp) pending_q.push_back('{value: row.value, sat: row.sat});
    else pending_q.push_back(cheb_eval(row.kind, row.degree, row.abscissa));
  endtask

  // Reset, directed table, random items, drain
  initial begin
    stim_row_t row;
    errors       = 0;
    results_seen = 0;
    snd_burst    = 0;
    rcv_burst    = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_kind     <= 1'b0;
    in_degree   <= '0;
    in_abscissa <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) offer(DIR_ROWS[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      row.kind     = 1'($urandom_range(0, 1));
      row.degree   = pick_degree();
      row.abscissa = pick_abscissa();
      row.has_exp  = 1'b0;
      row.value    = '0;
      row.sat      = 1'b0;
      offer(row);
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Receiver: random ready with one long hold-off while the sender keeps going
  initial begin
    int  stall;
    bit  hold_done;
    hold_done  = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        stall = idle_len(rcv_burst);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    cheb_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: value=%0d sat=%0b",
                                out_value, out_saturated));
      end else begin
        want = pending_q.pop_front();
        if (out_value !== want.value)
          note_mismatch($sformatf("value expected %0d (0x%08h) got %0d (0x%08h)",
                                  want.value, want.value, out_value, out_value));
        if (out_saturated !== want.sat)
          note_mismatch($sformatf("saturated expected %0b got %0b",
                                  want.sat, out_saturated));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
sv/chebpe_pkg.sv
sv/chebpe_datapath.sv
sv/chebyshev_polynomial_eval.sv
verif/tb_top.sv
